@@ hw/rtl/swarq_pkg.sv @@
// ----------------------------------------------------------------------------
// swarq_pkg
// Shared types and constants of the window-protocol sender controller.
// ----------------------------------------------------------------------------
package swarq_pkg;

  // Largest window in packets; the advertised window field is 7 bits wide
  localparam logic [6:0] MAX_WINDOW = 7'd64;

  // Opcodes of an input transaction
  localparam logic [1:0] OP_ACK     = 2'd0;
  localparam logic [1:0] OP_TIMEOUT = 2'd1;
  localparam logic [1:0] OP_START   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_TOTAL   = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_WINDOW  = 2'd2;

  // Configuration reset values
  localparam logic [10:0] TOTAL_RST   = 11'd1;
  localparam logic [15:0] TIMEOUT_RST = 16'd15;
  localparam logic [6:0]  WINDOW_RST  = 7'd1;

  // floor(x / 10) = (x * RECIP_TEN) >> RECIP_SHIFT, exact for x < 2^22
  localparam logic [19:0] RECIP_TEN   = 20'd838861;
  localparam int unsigned RECIP_SHIFT = 23;

  // floor(w / 3) = (w * RECIP_THREE) >> 7, exact for w < 128
  localparam logic [12:0] RECIP_THREE = 13'd43;

  localparam logic [19:0] MUL_THIRTEEN = 20'd13;
  localparam logic [26:0] MUL_US       = 27'd1300;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [9:0]  ack_number;
    logic        ack_is_ours;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [9:0]  send_seq;
    logic [6:0]  adv_window;
    logic [16:0] tack_ms;
    logic [26:0] timer_period_us;
    logic        last_of_burst;
    logic        transfer_done;
  } result_t;

  // Round-trip history, entry 0 is the newest
  typedef logic [2:0][31:0] hist_t;

  // Timeout unit result
  typedef struct packed {
    logic        valid;
    logic [15:0] timeout;
    logic [16:0] tack;
    logic [26:0] period;
  } tmo_res_t;

endpackage

@@ hw/rtl/sliding_window_arq_sender_top.sv @@
// ----------------------------------------------------------------------------
// sliding_window_arq_sender_top
// Sender controller of a window protocol with go-back retransmission.
// ----------------------------------------------------------------------------
// Usage: drive item_i and raise start; the transaction is taken at a clock
// edge with start high and busy low. Start, timeout and acknowledgement
// transactions each emit the current window, one result per cycle on
// result_o with result_valid_o high for exactly that cycle; last_of_burst
// marks the final one. An acknowledgement once every packet is done gives
// a single result with transfer_done set. Opcode 3 is dropped.
// A start or timeout passes through the timeout unit before its first
// result; an acknowledgement first reads its send time from the memory
// and then does the same or gives the done result.
// Throughput: one transaction at a time; busy stays high until the last
// result has been emitted, or the timeout unit has answered for an empty
// window. The receiver cannot stall results. The per-packet rate is set by
// the single write port of the send-time memory, one timestamp each cycle.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i, and
// the user must do so only while the block is idle; the block does not
// enforce it. Reset loads the configuration defaults and the initial
// window state. The send-time memory has no reset and is not cleared.
// ----------------------------------------------------------------------------
module sliding_window_arq_sender_top
  import swarq_pkg::*;
#(
  parameter int unsigned MAX_PACKETS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  item_t       item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output result_t     result_o
);

  localparam int unsigned AW    = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam logic [31:0] MaxPk = 32'(MAX_PACKETS);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ACK  = 5'b00010,
    ST_CALC = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [10:0] cfg_total_q;
  logic [15:0] cfg_tmo_q;
  logic [6:0]  cfg_win_q;

  logic [10:0] base_q, base_d;
  logic [6:0]  win_q, win_d;
  logic [15:0] ti_q, ti_d;
  hist_t       hist_q, hist_d;
  logic        go_q, go_d;

  logic [9:0]  num_q;
  logic        ours_q;
  logic [31:0] now_q;
  logic [16:0] tack_q, tack_d;
  logic [26:0] per_q, per_d;
  logic [10:0] seq_q, seq_d;
  logic [6:0]  rem_q, rem_d;

  logic        accept;
  logic [10:0] total;
  logic [10:0] num_ext;
  logic [10:0] avail;
  logic [6:0]  cnt;
  logic [6:0]  win_start;
  logic [12:0] win_prod;
  logic [31:0] rd_data;
  tmo_res_t    tmo_res;

  logic [AW+10:0] waddr_ext;
  logic [AW+10:0] raddr_ext;

  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);
  assign num_ext = {1'b0, num_q};

  // Packet count limited by the memory depth
  assign total = ({21'd0, cfg_total_q} > MaxPk) ? MaxPk[10:0] : cfg_total_q;

  // Packets left to send in this window
  always_comb begin
    avail = (base_q < total) ? (total - base_q) : 11'd0;
    cnt   = (avail > {4'd0, win_q}) ? win_q : avail[6:0];
  end

  // Start window clamped to 1..MAX_WINDOW; window / 3 by reciprocal
  always_comb begin
    if (cfg_win_q == 7'd0) begin
      win_start = 7'd1;
    end else if (cfg_win_q > MAX_WINDOW) begin
      win_start = MAX_WINDOW;
    end else begin
      win_start = cfg_win_q;
    end
    win_prod = {6'd0, win_q} * RECIP_THREE;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_total_q <= TOTAL_RST;
      cfg_tmo_q   <= TIMEOUT_RST;
      cfg_win_q   <= WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOTAL:   cfg_total_q <= cfg_data_i[10:0];
        CFG_TIMEOUT: cfg_tmo_q   <= cfg_data_i;
        CFG_WINDOW:  cfg_win_q   <= cfg_data_i[6:0];
        default:     ;
      endcase
    end
  end

  // Sequencer: read the send time, update the window, smooth the timeout,
  // then emit one packet per cycle while recording its send time
  always_comb begin
    state_d = state_q;
    base_d  = base_q;
    win_d   = win_q;
    ti_d    = ti_q;
    hist_d  = hist_q;
    tack_d  = tack_q;
    per_d   = per_q;
    seq_d   = seq_q;
    rem_d   = rem_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (item_i.opcode)
            OP_START: begin
              base_d  = '0;
              win_d   = win_start;
              ti_d    = cfg_tmo_q;
              hist_d  = '0;
              state_d = ST_CALC;
            end
            OP_TIMEOUT: begin
              if (win_q > 7'd2) begin
                win_d = {1'b0, win_prod[12:7]};
              end
              state_d = ST_CALC;
            end
            OP_ACK: begin
              state_d = ST_ACK;
            end
            default: ;
          endcase
        end
      end
      ST_ACK: begin
        if (ours_q) begin
          if (num_ext >= total) begin
            base_d = total;
          end else if (num_ext >= base_q) begin
            hist_d[2] = hist_q[1];
            hist_d[1] = hist_q[0];
            hist_d[0] = now_q - rd_data;
            if (win_q < MAX_WINDOW) begin
              win_d = win_q + 7'd1;
            end
            base_d = num_ext + 11'd1;
          end
        end
        state_d = (base_d >= total) ? ST_DONE : ST_CALC;
      end
      ST_CALC: begin
        if (tmo_res.valid) begin
          ti_d   = tmo_res.timeout;
          tack_d = tmo_res.tack;
          per_d  = tmo_res.period;
          seq_d  = base_q;
          rem_d  = cnt;
          state_d = (cnt == 7'd0) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        seq_d = seq_q + 11'd1;
        rem_d = rem_q - 7'd1;
        if (rem_q == 7'd1) begin
          state_d = ST_IDLE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Launch the timeout unit as CALC is entered, once the window state and
  // history have settled
  assign go_d = (state_d == ST_CALC) && (state_q != ST_CALC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      go_q    <= 1'b0;
      base_q  <= '0;
      win_q   <= WINDOW_RST;
      ti_q    <= TIMEOUT_RST;
      hist_q  <= '0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      base_q  <= base_d;
      win_q   <= win_d;
      ti_q    <= ti_d;
      hist_q  <= hist_d;
    end
  end

  // Transaction payload and emission registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_q  <= item_i.ack_number;
      ours_q <= item_i.ack_is_ours;
      now_q  <= item_i.now_ms;
    end
    tack_q <= tack_d;
    per_q  <= per_d;
    seq_q  <= seq_d;
    rem_q  <= rem_d;
  end

  swarq_tmo u_tmo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (go_q),
    .timeout_i (ti_q),
    .hist_i    (hist_q),
    .res_o     (tmo_res)
  );

  // Send-time memory; reads happen only at acceptance and writes only while
  // emitting, so one transaction at a time never overlaps the two
  assign waddr_ext = {{AW{1'b0}}, seq_q};
  assign raddr_ext = {{(AW + 1){1'b0}}, item_i.ack_number};

  swarq_stmem #(
    .DEPTH (MAX_PACKETS),
    .AW    (AW)
  ) u_stmem (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_EMIT),
    .waddr_i (waddr_ext[AW-1:0]),
    .wdata_i (now_q),
    .re_i    (accept && (item_i.opcode == OP_ACK)),
    .raddr_i (raddr_ext[AW-1:0]),
    .rdata_o (rd_data)
  );

  // Result port
  always_comb begin
    result_o       = '0;
    result_valid_o = 1'b0;
    if (state_q == ST_EMIT) begin
      result_valid_o           = 1'b1;
      result_o.send_seq        = seq_q[9:0];
      result_o.adv_window      = win_q;
      result_o.tack_ms         = tack_q;
      result_o.timer_period_us = per_q;
      result_o.last_of_burst   = (rem_q == 7'd1);
    end else if (state_q == ST_DONE) begin
      result_valid_o         = 1'b1;
      result_o.transfer_done = 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  // The done transaction is a single result followed by idle
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.transfer_done |=> !result_valid_o && !busy)
    else $error("done result not single");

  // The last packet of a burst returns the block to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_of_burst |=> !busy)
    else $error("busy after last packet");

  // Emitted packets carry a legal window
  a_win_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.transfer_done |->
      result_o.adv_window != 7'd0 && result_o.adv_window <= MAX_WINDOW)
    else $error("window out of range");

  // Send-time reads and writes never share a cycle
  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !(accept && (item_i.opcode == OP_ACK)))
    else $error("memory read during emission");

  // The timeout unit only answers while a calculation is pending
  a_tmo_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tmo_res.valid |-> state_q == ST_CALC)
    else $error("timeout result outside calculation");
`endif

endmodule

@@ hw/rtl/swarq_stmem.sv @@
// ----------------------------------------------------------------------------
// swarq_stmem
// Send-time memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swarq_stmem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  // Synchronous write and read; the read data is registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/swarq_tmo.sv @@
// ----------------------------------------------------------------------------
// swarq_tmo
// Timeout estimator: three-stage pipeline that smooths the timeout with the
// round-trip history and derives the header and timer reload values.
// ----------------------------------------------------------------------------
module swarq_tmo
  import swarq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [15:0] timeout_i,
  input  hist_t       hist_i,
  output tmo_res_t    res_o
);

  logic [2:0]  vld_q;
  logic [33:0] rtt_sum;
  logic [32:0] mix_sum;
  logic [15:0] tmo1_d;
  logic [15:0] tmo1_q, tmo2_q, tmo3_q;
  logic [19:0] x13_q;
  logic [26:0] per2_q, per3_q;
  logic [39:0] quot_prod;
  logic [16:0] tack_q;

  // Stage 1: ti = (ti + (2*r0 + r1 + r2) / 4) / 2, saturated to 16 bits
  always_comb begin
    rtt_sum = {1'b0, hist_i[0], 1'b0} + {2'b00, hist_i[1]} + {2'b00, hist_i[2]};
    mix_sum = {17'd0, timeout_i} + {1'b0, rtt_sum[33:2]};
    tmo1_d  = (mix_sum[32:1] > 32'd65535) ? 16'hFFFF : mix_sum[16:1];
  end

  // Stage 3 reciprocal multiply for the divide by ten
  assign quot_prod = {20'd0, x13_q} * {20'd0, RECIP_TEN};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], go_i};
    end
  end

  always_ff @(posedge clk_i) begin
    tmo1_q <= tmo1_d;
    // Stage 2: scale by 13 and by 1300
    tmo2_q <= tmo1_q;
    x13_q  <= {4'd0, tmo1_q} * MUL_THIRTEEN;
    per2_q <= {11'd0, tmo1_q} * MUL_US;
    // Stage 3: divide the x13 value by ten
    tmo3_q <= tmo2_q;
    per3_q <= per2_q;
    tack_q <= quot_prod[RECIP_SHIFT +: 17];
  end

  assign res_o.valid   = vld_q[2];
  assign res_o.timeout = tmo3_q;
  assign res_o.tack    = tack_q;
  assign res_o.period  = per3_q;

endmodule

@@ tb/sv/swarq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarq_checker
// Watches the transaction, configuration and result channels of the window
// sender, keeps its own model of the window state, and compares each result
// against the oldest expected one.
// ----------------------------------------------------------------------------
module swarq_checker
  import swarq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  item_t       item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        result_valid_i,
  input  result_t     result_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned items_o,
  output int unsigned results_o,
  output int unsigned done_o,
  output logic [10:0] base_o,
  output logic [10:0] sent_hi_o,
  output logic [10:0] total_o
);

  localparam logic [10:0] SEQ_SPACE    = 11'd1024;
  localparam int unsigned REPORT_LIMIT = 10;

  // Register copies
  logic [10:0] reg_total;
  logic [15:0] reg_timeout;
  logic [6:0]  reg_window;

  // Window state
  logic [10:0] base_seq;
  logic [6:0]  win_size;
  logic [15:0] tmo_est;
  logic [31:0] rtt_hist [3];
  logic [31:0] stamp_mem [1024];
  // every sequence number below this one has a stored send time
  logic [10:0] sent_hi;

  result_t     burst_q [$];
  int unsigned n_fail, n_items, n_results, n_done;

  function automatic logic [10:0] total_count();
    return (reg_total > SEQ_SPACE) ? SEQ_SPACE : reg_total;
  endfunction

  // Append one expected result at the tail of the queue
  function automatic void queue_result(input result_t r);
    burst_q = {burst_q, r};
  endfunction

  function automatic void reload_window();
    base_seq = '0;
    if (reg_window == 7'd0) win_size = 7'd1;
    else if (reg_window > MAX_WINDOW) win_size = MAX_WINDOW;
    else win_size = reg_window;
    tmo_est  = reg_timeout;
    for (int i = 0; i < 3; i++) rtt_hist[i] = '0;
  endfunction

  // Refresh the timeout estimate, then queue the packets of the window
  function automatic void emit_burst(input logic [31:0] now);
    logic [33:0] avg;
    logic [32:0] mix;
    logic [31:0] wide_tack, wide_period;
    logic [10:0] total, count, seq;
    result_t     r;
    avg = ({2'b00, rtt_hist[0]} << 1) + {2'b00, rtt_hist[1]} + {2'b00, rtt_hist[2]};
    avg = avg >> 2;
    mix = ({17'b0, tmo_est} + {1'b0, avg[31:0]}) >> 1;
    tmo_est = (mix > 33'd65535) ? 16'hFFFF : mix[15:0];
    total = total_count();
    count = (base_seq < total) ? total - base_seq : 11'd0;
    if (count > {4'b0, win_size}) count = {4'b0, win_size};
    wide_tack   = ({16'b0, tmo_est} * 32'd13) / 32'd10;
    wide_period = {16'b0, tmo_est} * 32'd1300;
    for (int k = 0; k < count; k++) begin
      seq = base_seq + k[10:0];
      r.send_seq        = seq[9:0];
      r.adv_window      = win_size;
      r.tack_ms         = wide_tack[16:0];
      r.timer_period_us = wide_period[26:0];
      r.last_of_burst   = (k + 1 == count);
      r.transfer_done   = 1'b0;
      queue_result(r);
      stamp_mem[seq[9:0]] = now;
    end
    if (base_seq + count > sent_hi) sent_hi = base_seq + count;
  endfunction

  function automatic void apply_item(input item_t it);
    logic [10:0] total;
    logic [10:0] num;
    result_t     fin;
    total = total_count();
    num   = {1'b0, it.ack_number};
    case (it.opcode)
      OP_START: begin
        reload_window();
        emit_burst(it.now_ms);
      end
      OP_TIMEOUT: begin
        if (win_size > 7'd2) win_size = win_size / 7'd3;
        emit_burst(it.now_ms);
      end
      OP_ACK: begin
        // cumulative ack; only our own peer moves the window
        if (it.ack_is_ours) begin
          if (num >= total) begin
            base_seq = total;
          end else if (num >= base_seq) begin
            rtt_hist[2] = rtt_hist[1];
            rtt_hist[1] = rtt_hist[0];
            rtt_hist[0] = it.now_ms - stamp_mem[it.ack_number];
            if (win_size < MAX_WINDOW) win_size = win_size + 7'd1;
            base_seq = num + 11'd1;
          end
        end
        if (base_seq >= total) begin
          fin = '0;
          fin.transfer_done = 1'b1;
          queue_result(fin);
        end else begin
          emit_burst(it.now_ms);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result(input result_t got);
    result_t want;
    n_results++;
    if (got.transfer_done) n_done++;
    if (burst_q.size() == 0) begin
      n_fail++;
      if (n_fail <= REPORT_LIMIT)
        $display("[%0t] result with nothing expected: seq=%0d win=%0d done=%0b",
                 $realtime, got.send_seq, got.adv_window, got.transfer_done);
      return;
    end
    want = burst_q.pop_front();
    if (got !== want) begin
      n_fail++;
      if (n_fail <= REPORT_LIMIT) begin
        $display("[%0t] result mismatch", $realtime);
        $display("  expected seq=%0d win=%0d tack=%0d period=%0d last=%0b done=%0b",
                 want.send_seq, want.adv_window, want.tack_ms, want.timer_period_us,
                 want.last_of_burst, want.transfer_done);
        $display("  actual   seq=%0d win=%0d tack=%0d period=%0d last=%0b done=%0b",
                 got.send_seq, got.adv_window, got.tack_ms, got.timer_period_us,
                 got.last_of_burst, got.transfer_done);
      end
    end
  endfunction

  // Results first: a transaction taken in the same cycle cannot own them yet
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_total   = TOTAL_RST;
      reg_timeout = TIMEOUT_RST;
      reg_window  = WINDOW_RST;
      reload_window();
      sent_hi     = '0;
      burst_q.delete();
      n_fail      = 0;
      n_items     = 0;
      n_results   = 0;
      n_done      = 0;
    end else begin
      if (result_valid_i) check_result(result_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TOTAL:   reg_total   = cfg_data_i[10:0];
          CFG_TIMEOUT: reg_timeout = cfg_data_i;
          CFG_WINDOW:  reg_window  = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        n_items++;
        apply_item(item_i);
      end
    end
    fail_count_o <= n_fail;
    pending_o    <= burst_q.size();
    items_o      <= n_items;
    results_o    <= n_results;
    done_o       <= n_done;
    base_o       <= base_seq;
    sent_hi_o    <= sent_hi;
    total_o      <= total_count();
  end

endmodule

@@ tb/sv/tb_sliding_window_arq_sender_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_arq_sender_top
// Drives start, timeout and acknowledgement transactions plus register
// writes into the window sender; the checker beside it predicts and compares
// every result. Directed corner cases first, then randomized transfers.
// ----------------------------------------------------------------------------
module tb_sliding_window_arq_sender_top;
  import swarq_pkg::*;

  localparam logic [1:0]  OP_NONE      = 2'd3;
  localparam logic [1:0]  CFG_SPARE    = 2'd3;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 58;
  localparam int unsigned DRAIN_CYCLES = 12;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        start    = 1'b0;
  item_t       item     = '0;
  logic        cfg_we   = 1'b0;
  logic [1:0]  cfg_idx  = '0;
  logic [15:0] cfg_data = '0;
  logic        busy;
  logic        res_valid;
  result_t     res;

  int unsigned fail_count, pending, n_items, n_results, n_done;
  logic [10:0] base_seq, sent_hi, total;

  logic [31:0] clock_ms;
  bit          gaps_on;
  int unsigned n_settings;

  sliding_window_arq_sender_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .result_valid_o (res_valid),
    .result_o       (res)
  );

  swarq_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .result_valid_i (res_valid),
    .result_i       (res),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .items_o        (n_items),
    .results_o      (n_results),
    .done_o         (n_done),
    .base_o         (base_seq),
    .sent_hi_o      (sent_hi),
    .total_o        (total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Millisecond clock: mostly small steps, sometimes long silences or jumps
  function automatic logic [31:0] tick();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) clock_ms = $urandom;
    else if (r < 3) clock_ms = clock_ms + $urandom_range(1000, 200000);
    else clock_ms = clock_ms + $urandom_range(0, 400);
    return clock_ms;
  endfunction

  task automatic pause();
    if (gaps_on && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 14)) @(posedge clk);
  endtask

  // One transaction; an own ack of a never-sent packet is turned foreign
  task automatic issue(input logic [1:0] op, input logic [9:0] num, input logic ours);
    item_t it;
    it.opcode      = op;
    it.ack_number  = num;
    it.now_ms      = tick();
    it.ack_is_ours = ours && (op != OP_ACK || {1'b0, num} >= total ||
                              {1'b0, num} < base_seq || {1'b0, num} < sent_hi);
    pause();
    item  <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] tot, input logic [15:0] tmo,
                           input logic [15:0] win);
    settle();
    write_reg(CFG_TOTAL, tot);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_WINDOW, win);
    n_settings++;
  endtask

  // Mostly in-order acks just past the window base, plus stale, overshooting
  // and foreign ones
  task automatic random_ack();
    logic [10:0] hi, span;
    logic [9:0]  num;
    int unsigned r, step;
    r  = $urandom_range(0, 99);
    hi = (sent_hi < total) ? sent_hi : total;
    if (r < 62 && hi > base_seq) begin
      span = hi - base_seq;
      if ($urandom_range(0, 3) == 0) step = $urandom_range(0, span - 1);
      else step = $urandom_range(0, (span > 4) ? 3 : span - 1);
      num = 10'(base_seq + step[10:0]);
      issue(OP_ACK, num, 1'b1);
    end else if (r < 72 && base_seq > 0) begin
      num = 10'($urandom_range(0, base_seq - 1));
      issue(OP_ACK, num, 1'b1);
    end else if (r < 80 && total < 11'd1024) begin
      num = 10'($urandom_range(total, 1023));
      issue(OP_ACK, num, 1'b1);
    end else begin
      num = 10'($urandom_range(0, 1023));
      issue(OP_ACK, num, 1'b0);
    end
  endtask

  task automatic random_item();
    int unsigned r;
    logic [9:0]  num;
    logic        ours;
    r    = $urandom_range(0, 99);
    num  = 10'($urandom_range(0, 1023));
    ours = 1'($urandom_range(0, 1));
    if (base_seq >= total && r < 40) issue(OP_START, num, ours);
    else if (r < 64) random_ack();
    else if (r < 84) issue(OP_TIMEOUT, num, ours);
    else if (r < 90) issue(OP_START, num, ours);
    else if (r < 94) issue(OP_NONE, num, ours);
    else random_ack();
  endtask

  initial begin
    clock_ms   = 32'hFFFF_FF00;
    gaps_on    = 1'b0;
    n_settings = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults after reset: one packet, window 1
    issue(OP_NONE, 10'h3FF, 1'b1);      // dropped opcode
    issue(OP_ACK, 10'h3FF, 1'b0);       // foreign ack still emits
    issue(OP_TIMEOUT, 10'd0, 1'b0);
    issue(OP_ACK, 10'd0, 1'b1);         // final packet acked
    issue(OP_ACK, 10'd0, 1'b1);         // done repeats
    issue(OP_TIMEOUT, 10'd0, 1'b0);     // empty window
    issue(OP_START, 10'd0, 1'b0);

    // All register bits set: totals clamp, window clamps to its maximum
    settle();
    write_reg(CFG_SPARE, 16'h5A5A);
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(OP_START, 10'd0, 1'b0);
    clock_ms = clock_ms + 32'hF000_0000;
    issue(OP_ACK, 10'd63, 1'b1);        // huge round trip, saturating window
    issue(OP_TIMEOUT, 10'd0, 1'b0);
    issue(OP_ACK, 10'd5, 1'b1);         // below base
    issue(OP_ACK, 10'd600, 1'b0);
    issue(OP_ACK, 10'd127, 1'b1);

    // Tiny transfer, zero timeout, window register zero
    configure(16'd3, 16'd0, 16'd0);
    issue(OP_START, 10'd0, 1'b0);
    issue(OP_ACK, 10'd0, 1'b1);
    issue(OP_TIMEOUT, 10'd0, 1'b0);
    issue(OP_ACK, 10'd1000, 1'b1);      // beyond the transfer: all done
    issue(OP_ACK, 10'd1, 1'b0);
    issue(OP_TIMEOUT, 10'd0, 1'b0);
    issue(OP_START, 10'd0, 1'b0);
    issue(OP_ACK, 10'd2, 1'b1);

    // Randomized transfers over several register settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(16'd1024, 16'hFFFF, 16'd64);
        1: configure(16'd1, 16'd0, 16'd1);
        default: configure(16'(($urandom_range(0, 3) == 0) ? $urandom_range(49, 1024)
                                                             : $urandom_range(2, 48)),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 127)));
      endcase
      issue(OP_START, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 16 == 0) gaps_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
        random_item();
      end
    end

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d transactions and %0d results (%0d transfer-complete)",
             n_items, n_results, n_done);
    $display("across %0d register settings; %0d mismatches", n_settings, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sliding_window_arq_sender_top.f @@
hw/rtl/swarq_pkg.sv
hw/rtl/swarq_stmem.sv
hw/rtl/swarq_tmo.sv
hw/rtl/sliding_window_arq_sender_top.sv
tb/sv/swarq_checker.sv
tb/sv/tb_sliding_window_arq_sender_top.sv
